FILE: sv/mspf_pkg.sv
// Shared types, character codes and the CRC-8 helper for the MSP v2 frame parser.
// No dependencies.
`timescale 1ns / 1ps

package mspf_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DOLLAR  = 4'd1,
    PH_X       = 4'd2,
    PH_FLAG    = 4'd3,
    PH_FUNC_LO = 4'd4,
    PH_FUNC_HI = 4'd5,
    PH_SIZE_LO = 4'd6,
    PH_SIZE_HI = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_CRC     = 4'd9
  } phase_t;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_X      = 8'h58;  // 'X'
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'

  // Direction codes
  localparam logic [1:0] DIR_REQUEST = 2'd0;
  localparam logic [1:0] DIR_REPLY   = 2'd1;
  localparam logic [1:0] DIR_ERROR   = 2'd2;

  // Result kinds
  localparam logic RK_PAYLOAD   = 1'b0;
  localparam logic RK_FRAME_END = 1'b1;

  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [15:0] SIZE_LIMIT_RST = 16'd256;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [1:0]  direction;
    logic [7:0]  flag_byte;
    logic [15:0] function_id;
    logic [15:0] payload_size;
    logic        crc_ok;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } res_t;

  // CRC-8/DVB-S2 over one byte, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/mspf_in_if.sv
// Input channel of the MSP v2 frame parser: one received byte per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface mspf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/mspf_out_if.sv
// Result channel of the MSP v2 frame parser: payload bytes and frame-end records.
// No dependencies.
`timescale 1ns / 1ps

interface mspf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [1:0]  direction;
  logic [7:0]  flag_byte;
  logic [15:0] function_id;
  logic [15:0] payload_size;
  logic        crc_ok;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output direction, output flag_byte, output function_id, output payload_size,
    output crc_ok, output good_frames, output bad_frames,
    input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input direction, input flag_byte, input function_id, input payload_size,
    input crc_ok, input good_frames, input bad_frames,
    output ready
  );
endinterface

FILE: sv/msp_v2_frame_parser_top.sv
// MSP v2 frame parser top level: framing state machine, CRC-8 and result register.
// Depends on mspf_pkg, mspf_in_if and mspf_out_if.
`timescale 1ns / 1ps

// The parser takes one received byte per transaction and follows MSP v2 framing:
// '$', 'X', a direction byte ('<', '>' or '!'), the flag, a little-endian
// function code and payload size, the payload, then one CRC-8/DVB-S2 byte that
// covers flag through payload. Every payload byte leaves as its own result with
// its index; the CRC byte produces a frame-end result with the header, crc_ok
// and the running good and bad frame counts (both wrap at 32 bits). Frames whose
// declared size exceeds the size limit register are dropped without a result,
// and the parser goes back to hunting for '$'. Drop the streamed payload
// downstream when crc_ok is 0. The state update and the CRC step run between
// the state registers and a single result register, so a byte is accepted
// every cycle as long as the result register is empty or is being read in
// that same cycle. The size limit resets to 256; write it while the parser
// is idle. It is sampled when the high size byte arrives.
module msp_v2_frame_parser_top import mspf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mspf_in_if.sink     rx_chan,
  mspf_out_if.source  res_chan
);

  // Parser state
  phase_t      phase;
  phase_t      phase_next;
  logic [1:0]  frame_direction;
  logic [1:0]  frame_direction_next;
  logic [7:0]  frame_flag;
  logic [7:0]  frame_flag_next;
  logic [15:0] frame_function;
  logic [15:0] frame_function_next;
  logic [15:0] frame_size;
  logic [15:0] frame_size_next;
  logic [15:0] bytes_received;
  logic [15:0] bytes_received_next;
  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [31:0] good_count;
  logic [31:0] good_count_next;
  logic [31:0] bad_count;
  logic [31:0] bad_count_next;
  logic [15:0] size_limit;

  // Result register
  logic        res_valid;
  res_t        res;
  res_t        res_next;
  logic        emit;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  crc_step;
  logic [15:0] size_full;
  logic [15:0] received_inc;
  logic        crc_match;

  // Take a new byte whenever the result register is free or drains this cycle
  assign rx_chan.ready = !res_valid || res_chan.ready;
  assign accept        = rx_chan.valid && rx_chan.ready;
  assign b             = rx_chan.rx_byte;

  assign crc_step     = crc8_update(running_crc, b);
  assign size_full    = {b, frame_size[7:0]};
  assign received_inc = bytes_received + 16'd1;
  assign crc_match    = (b == running_crc);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DOLLAR:  phase_next = (b == CH_X) ? PH_X : PH_IDLE;
      PH_X: begin
        if (b inside {CH_LT, CH_GT, CH_BANG}) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_FLAG:    phase_next = PH_FUNC_LO;
      PH_FUNC_LO: phase_next = PH_FUNC_HI;
      PH_FUNC_HI: phase_next = PH_SIZE_LO;
      PH_SIZE_LO: phase_next = PH_SIZE_HI;
      PH_SIZE_HI: begin
        // Oversize frames resynchronize silently
        if (size_full > size_limit) begin
          phase_next = PH_IDLE;
        end else if (size_full == 16'd0) begin
          phase_next = PH_CRC;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: phase_next = (received_inc == frame_size) ? PH_CRC : PH_PAYLOAD;
      PH_CRC:     phase_next = PH_IDLE;
      default:    phase_next = (b == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
    endcase
  end

  // Frame fields, CRC, counters and result
  always_comb begin
    frame_direction_next = frame_direction;
    frame_flag_next      = frame_flag;
    frame_function_next  = frame_function;
    frame_size_next      = frame_size;
    bytes_received_next  = bytes_received;
    running_crc_next     = running_crc;
    good_count_next      = good_count;
    bad_count_next       = bad_count;
    emit                 = 1'b0;
    res_next             = '0;
    case (phase)
      PH_X: begin
        if (b == CH_LT) begin
          frame_direction_next = DIR_REQUEST;
        end else if (b == CH_GT) begin
          frame_direction_next = DIR_REPLY;
        end else begin
          frame_direction_next = DIR_ERROR;
        end
        // Field values only matter once the direction byte is valid
        if (b inside {CH_LT, CH_GT, CH_BANG}) begin
          running_crc_next    = 8'd0;
          bytes_received_next = 16'd0;
        end else begin
          frame_direction_next = frame_direction;
        end
      end
      PH_FLAG: begin
        frame_flag_next  = b;
        running_crc_next = crc_step;
      end
      PH_FUNC_LO: begin
        frame_function_next = {8'd0, b};
        running_crc_next    = crc_step;
      end
      PH_FUNC_HI: begin
        frame_function_next = {b, frame_function[7:0]};
        running_crc_next    = crc_step;
      end
      PH_SIZE_LO: begin
        frame_size_next  = {8'd0, b};
        running_crc_next = crc_step;
      end
      PH_SIZE_HI: begin
        frame_size_next  = size_full;
        running_crc_next = crc_step;
      end
      PH_PAYLOAD: begin
        emit                   = 1'b1;
        res_next.result_kind   = RK_PAYLOAD;
        res_next.payload_byte  = b;
        res_next.payload_index = bytes_received;
        running_crc_next       = crc_step;
        bytes_received_next    = received_inc;
      end
      PH_CRC: begin
        emit = 1'b1;
        if (crc_match) begin
          good_count_next = good_count + 32'd1;
        end else begin
          bad_count_next = bad_count + 32'd1;
        end
        res_next.result_kind  = RK_FRAME_END;
        res_next.direction    = frame_direction;
        res_next.flag_byte    = frame_flag;
        res_next.function_id  = frame_function;
        res_next.payload_size = frame_size;
        res_next.crc_ok       = crc_match;
        res_next.good_frames  = good_count_next;
        res_next.bad_frames   = bad_count_next;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      frame_direction <= 2'd0;
      frame_flag      <= 8'd0;
      frame_function  <= 16'd0;
      frame_size      <= 16'd0;
      bytes_received  <= 16'd0;
      running_crc     <= 8'd0;
      good_count      <= 32'd0;
      bad_count       <= 32'd0;
      size_limit      <= SIZE_LIMIT_RST;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_limit <= cfg_wdata;
      end
      if (accept) begin
        phase           <= phase_next;
        frame_direction <= frame_direction_next;
        frame_flag      <= frame_flag_next;
        frame_function  <= frame_function_next;
        frame_size      <= frame_size_next;
        bytes_received  <= bytes_received_next;
        running_crc     <= running_crc_next;
        good_count      <= good_count_next;
        bad_count       <= bad_count_next;
        res_valid       <= emit;
      end else if (res_chan.ready) begin
        // Drop the result once it has been taken
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted byte that produces a result
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res <= res_next;
    end
  end

  assign res_chan.valid         = res_valid;
  assign res_chan.result_kind   = res.result_kind;
  assign res_chan.payload_byte  = res.payload_byte;
  assign res_chan.payload_index = res.payload_index;
  assign res_chan.direction     = res.direction;
  assign res_chan.flag_byte     = res.flag_byte;
  assign res_chan.function_id   = res.function_id;
  assign res_chan.payload_size  = res.payload_size;
  assign res_chan.crc_ok        = res.crc_ok;
  assign res_chan.good_frames   = res.good_frames;
  assign res_chan.bad_frames    = res.bad_frames;

`ifndef ASSERT_OFF
  // Payload phase never runs past the declared size
  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_received < frame_size))
    else $error("payload counter reached frame size inside payload phase");

  // A pending payload result belongs to the current frame
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.result_kind == RK_PAYLOAD) |-> (res.payload_index < frame_size))
    else $error("payload index outside frame");

  // A pending frame-end result carries the live counters
  a_counts_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.result_kind == RK_FRAME_END) |->
      (res.good_frames == good_count && res.bad_frames == bad_count))
    else $error("frame-end counters disagree with running counts");

  // A stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_chan.ready) |-> !rx_chan.ready)
    else $error("byte accepted while result register is stalled");
`endif

endmodule
